// ----- src/ffra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared codes and the command and status bundles that join the allocator's
// controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

  // Request codes
  localparam logic [2:0] RQ_ADD     = 3'd0;
  localparam logic [2:0] RQ_RESERVE = 3'd1;
  localparam logic [2:0] RQ_ALLOC   = 3'd2;
  localparam logic [2:0] RQ_FREE    = 3'd3;
  localparam logic [2:0] RQ_DUMP    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Which slot a write or list insert targets
  typedef enum logic [1:0] {
    SL_SPARE = 2'd0,
    SL_CUR   = 2'd1,
    SL_SAVE  = 2'd2
  } slot_sel_t;

  // Source of a written start address
  typedef enum logic [2:0] {
    SS_NONE = 3'd0,
    SS_BASE = 3'd1,
    SS_BP1  = 3'd2,
    SS_H    = 3'd3,
    SS_AT   = 3'd4,
    SS_ATSZ = 3'd5
  } start_src_t;

  // Source of a written length
  typedef enum logic [3:0] {
    LS_NONE = 4'd0,
    LS_CLIP = 4'd1,
    LS_LMB  = 4'd2,
    LS_AMH  = 4'd3,
    LS_GAP  = 4'd4,
    LS_SIZE = 4'd5,
    LS_REM  = 4'd6,
    LS_SAT  = 4'd7,
    LS_ACC  = 4'd8
  } len_src_t;

  // Kind of result loaded into the output registers
  typedef enum logic [1:0] {
    EM_NONE   = 2'd0,
    EM_STATUS = 2'd1,
    EM_DUMP   = 2'd2
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;
    logic       list;
    logic       rd;
    logic       pos_clr;
    logic       pos_inc;
    logic       put;
    logic       drop;
    slot_sel_t  slot;
    start_src_t wr_start;
    len_src_t   wr_len;
    logic       key_sum;
    logic       acc_rd;
    logic       acc_sat;
    logic       save_slot;
    emit_t      emit;
    logic [1:0] code;
    logic       addr_en;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       usable_ok;
    logic       a_gt_b;
    logic       bad_align;
    logic       dump_used;
    logic       dump_empty;
    logic       dump_last;
    logic       more;
    logic       spare_zero;
    logic       spare_short;
    logic       split;
    logic       outside;
    logic       contain;
    logic       h_lt_a;
    logic       fit;
    logic       gap_nz;
    logic       rem_nz;
    logic       hit;
    logic       fwd_ok;
    logic       sum_hit;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/first_fit_region_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top
// First-fit region allocator with coalescing over a pool of region slots.
//
//   channel  | direction | handshake                  | payload
//   request  | in        | start & !busy              | req_type .. dump_limit
//   result   | out       | result_strobe (one cycle)  | status .. last
//
// An entry visit is a list check, a memory read, a three-stage compare and
// the decision, in that order; an allocation adds its split states (S_ALCB,
// then S_ALCC or S_ALCD), and a free makes up to three scans (the allocated
// list, then the free list twice). A dump reads each entry before it emits
// it. Reset clears the list counts at once; no clearing pass.
// Results cannot be stalled; busy stays high until the last one is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator_top #(
  parameter int POOL_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [63:0] base_addr,
  input  logic [63:0] size_value,
  input  logic [63:0] range_tail,
  input  logic [32:0] align_bytes,
  input  logic        usable,
  input  logic        dump_used,
  input  logic [5:0]  dump_limit,
  output logic        result_strobe,
  output logic [1:0]  status,
  output logic [63:0] result_addr,
  output logic [63:0] entry_start,
  output logic [63:0] entry_length,
  output logic [5:0]  entry_number,
  output logic        last
);
  import ffra_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ffra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  ffra_dp #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .req_type      (req_type),
    .base_addr     (base_addr),
    .size_value    (size_value),
    .range_tail    (range_tail),
    .align_bytes   (align_bytes),
    .usable        (usable),
    .dump_used     (dump_used),
    .dump_limit    (dump_limit),
    .result_strobe (result_strobe),
    .status        (status),
    .result_addr   (result_addr),
    .entry_start   (entry_start),
    .entry_length  (entry_length),
    .entry_number  (entry_number),
    .last          (last)
  );

endmodule

`default_nettype wire

// ----- src/ffra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffra_ctrl
// Request sequencer: walks the free or allocated list one entry at a time
// and issues list, memory and result commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ffra_pkg::stat_t st,
  output ffra_pkg::cmd_t  cmd
);
  import ffra_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_CHECK = 14'b00000000000100,
    S_RD    = 14'b00000000001000,
    S_E1    = 14'b00000000010000,
    S_E2    = 14'b00000000100000,
    S_E3    = 14'b00000001000000,
    S_DEC   = 14'b00000010000000,
    S_RES2  = 14'b00000100000000,
    S_ALCB  = 14'b00001000000000,
    S_ALCC  = 14'b00010000000000,
    S_ALCD  = 14'b00100000000000,
    S_DRD   = 14'b01000000000000,
    S_DEM   = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_ADD  = 3'd0,
    PH_RES  = 3'd1,
    PH_ALC  = 3'd2,
    PH_FREE = 3'd3,
    PH_FWD  = 3'd4,
    PH_BACK = 3'd5
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   changed, changed_next;
  logic   scan_list;

  assign busy = (state != S_IDLE);

  // The first scan of a free request walks the allocated list, dumps the selected list,
  // all others the free list
  always_comb begin
    if (state == S_DRD || state == S_DEM) begin
      scan_list = st.dump_used;
    end else if (state == S_DISP) begin
      scan_list = (st.req_type == RQ_DUMP) ? st.dump_used : 1'b0;
    end else begin
      scan_list = (phase == PH_FREE);
    end
  end

  // Sequence the request
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    changed_next = changed;
    cmd          = '0;
    cmd.list     = scan_list;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.pos_clr = 1'b1;
        case (st.req_type)
          RQ_ADD: begin
            phase_next = PH_ADD;
            state_next = S_E1;
          end
          RQ_RESERVE: begin
            if (st.a_gt_b) begin
              cmd.emit   = EM_STATUS;
              cmd.code   = ST_NONE;
              state_next = S_IDLE;
            end else begin
              phase_next   = PH_RES;
              changed_next = 1'b0;
              state_next   = S_CHECK;
            end
          end
          RQ_ALLOC: begin
            if (st.bad_align) begin
              cmd.emit   = EM_STATUS;
              cmd.code   = ST_NONE;
              state_next = S_IDLE;
            end else begin
              phase_next = PH_ALC;
              state_next = S_CHECK;
            end
          end
          RQ_FREE: begin
            phase_next = PH_FREE;
            state_next = S_CHECK;
          end
          RQ_DUMP: begin
            if (st.dump_empty) begin
              cmd.emit   = EM_STATUS;
              cmd.code   = ST_NONE;
              state_next = S_IDLE;
            end else begin
              state_next = S_DRD;
            end
          end
          default: begin
            cmd.emit   = EM_STATUS;
            cmd.code   = ST_NONE;
            state_next = S_IDLE;
          end
        endcase
      end
      S_CHECK: begin
        if (st.more) begin
          state_next = S_RD;
        end else begin
          state_next = S_IDLE;
          cmd.emit   = EM_STATUS;
          case (phase)
            PH_RES:  cmd.code = changed ? ST_OK : ST_NONE;
            PH_FREE: cmd.code = ST_MISS;
            PH_FWD: begin
              cmd.emit    = EM_NONE;
              cmd.pos_clr = 1'b1;
              phase_next  = PH_BACK;
              state_next  = S_CHECK;
            end
            PH_BACK: begin
              // no neighbor below: insert the freed region at the free head
              cmd.list     = 1'b0;
              cmd.put      = 1'b1;
              cmd.slot     = SL_SAVE;
              cmd.wr_start = SS_BASE;
              cmd.wr_len   = LS_ACC;
              cmd.code     = ST_OK;
            end
            default: cmd.code = ST_NONE;
          endcase
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_E1;
      end
      S_E1: state_next = S_E2;
      S_E2: state_next = S_E3;
      S_E3: state_next = S_DEC;
      S_DEC: begin
        state_next = S_CHECK;
        case (phase)
          PH_ADD: begin
            state_next = S_IDLE;
            cmd.emit   = EM_STATUS;
            if (!st.usable_ok) begin
              cmd.code = ST_NONE;
            end else if (st.spare_zero) begin
              cmd.code = ST_FULL;
            end else begin
              cmd.list     = 1'b0;
              cmd.put      = 1'b1;
              cmd.slot     = SL_SPARE;
              cmd.wr_start = SS_BASE;
              cmd.wr_len   = LS_CLIP;
              cmd.code     = ST_OK;
            end
          end
          PH_RES: begin
            if (st.split) begin
              if (st.spare_zero) begin
                cmd.emit   = EM_STATUS;
                cmd.code   = ST_FULL;
                state_next = S_IDLE;
              end else begin
                cmd.put      = 1'b1;
                cmd.slot     = SL_SPARE;
                cmd.wr_start = SS_BP1;
                cmd.wr_len   = LS_LMB;
                state_next   = S_RES2;
              end
            end else if (st.outside) begin
              cmd.pos_inc = 1'b1;
            end else begin
              changed_next = 1'b1;
              if (st.contain) begin
                cmd.drop = 1'b1;
              end else if (st.h_lt_a) begin
                cmd.slot    = SL_CUR;
                cmd.wr_len  = LS_AMH;
                cmd.pos_inc = 1'b1;
              end else begin
                cmd.slot     = SL_CUR;
                cmd.wr_start = SS_BP1;
                cmd.wr_len   = LS_LMB;
                cmd.pos_inc  = 1'b1;
              end
            end
          end
          PH_ALC: begin
            if (!st.fit) begin
              cmd.pos_inc = 1'b1;
            end else if (st.spare_short) begin
              cmd.emit   = EM_STATUS;
              cmd.code   = ST_FULL;
              state_next = S_IDLE;
            end else begin
              state_next = S_ALCB;
              if (st.gap_nz) begin
                // alignment gap goes to the free head, ahead of this entry
                cmd.put      = 1'b1;
                cmd.slot     = SL_SPARE;
                cmd.wr_start = SS_H;
                cmd.wr_len   = LS_GAP;
                cmd.pos_inc  = 1'b1;
              end
            end
          end
          PH_FREE: begin
            if (st.hit) begin
              cmd.acc_rd    = 1'b1;
              cmd.save_slot = 1'b1;
              cmd.drop      = 1'b1;
              cmd.pos_clr   = 1'b1;
              if (st.fwd_ok) begin
                cmd.key_sum = 1'b1;
                phase_next  = PH_FWD;
              end else begin
                phase_next = PH_BACK;
              end
            end else begin
              cmd.pos_inc = 1'b1;
            end
          end
          PH_FWD: begin
            if (st.hit) begin
              cmd.acc_sat = 1'b1;
              cmd.drop    = 1'b1;
              cmd.pos_clr = 1'b1;
              phase_next  = PH_BACK;
            end else begin
              cmd.pos_inc = 1'b1;
            end
          end
          PH_BACK: begin
            if (st.sum_hit) begin
              cmd.slot   = SL_CUR;
              cmd.wr_len = LS_SAT;
              cmd.emit   = EM_STATUS;
              cmd.code   = ST_OK;
              state_next = S_IDLE;
            end else begin
              cmd.pos_inc = 1'b1;
            end
          end
          default: begin
            cmd.emit   = EM_STATUS;
            cmd.code   = ST_NONE;
            state_next = S_IDLE;
          end
        endcase
      end
      S_RES2: begin
        cmd.slot   = SL_CUR;
        cmd.wr_len = LS_AMH;
        cmd.emit   = EM_STATUS;
        cmd.code   = ST_OK;
        state_next = S_IDLE;
      end
      S_ALCB: begin
        if (st.rem_nz) begin
          cmd.list     = 1'b1;
          cmd.put      = 1'b1;
          cmd.slot     = SL_SPARE;
          cmd.wr_start = SS_AT;
          cmd.wr_len   = LS_SIZE;
          state_next   = S_ALCC;
        end else begin
          cmd.list   = 1'b0;
          cmd.drop   = 1'b1;
          state_next = S_ALCD;
        end
      end
      S_ALCC: begin
        cmd.slot     = SL_CUR;
        cmd.wr_start = SS_ATSZ;
        cmd.wr_len   = LS_REM;
        cmd.emit     = EM_STATUS;
        cmd.code     = ST_OK;
        cmd.addr_en  = 1'b1;
        state_next   = S_IDLE;
      end
      S_ALCD: begin
        cmd.list     = 1'b1;
        cmd.put      = 1'b1;
        cmd.slot     = SL_CUR;
        cmd.wr_start = SS_AT;
        cmd.wr_len   = LS_SIZE;
        cmd.emit     = EM_STATUS;
        cmd.code     = ST_OK;
        cmd.addr_en  = 1'b1;
        state_next   = S_IDLE;
      end
      S_DRD: begin
        cmd.rd     = 1'b1;
        state_next = S_DEM;
      end
      S_DEM: begin
        cmd.emit = EM_DUMP;
        if (st.dump_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = S_DRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_ADD;
      changed <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      changed <= changed_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/ffra_dp.sv -----
// ----------------------------------------------------------------------------
// ffra_dp
// Allocator datapath: region memories, the two ordered slot lists, the
// compare pipeline for one list entry and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_dp #(
  parameter int POOL_ENTRIES = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  ffra_pkg::cmd_t  cmd,
  output ffra_pkg::stat_t st,
  input  logic [2:0]      req_type,
  input  logic [63:0]     base_addr,
  input  logic [63:0]     size_value,
  input  logic [63:0]     range_tail,
  input  logic [32:0]     align_bytes,
  input  logic            usable,
  input  logic            dump_used,
  input  logic [5:0]      dump_limit,
  output logic            result_strobe,
  output logic [1:0]      status,
  output logic [63:0]     result_addr,
  output logic [63:0]     entry_start,
  output logic [63:0]     entry_length,
  output logic [5:0]      entry_number,
  output logic            last
);
  import ffra_pkg::*;

  localparam int SW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int KW = (CW > 6) ? CW : 6;

  // Latched request
  logic [2:0]  type_r;
  logic [63:0] base_r, size_r, tail_r;
  logic [32:0] align_r;
  logic        usable_r, used_r;
  logic [5:0]  limit_r;

  // List state
  logic [SW-1:0]   ord_f [POOL_ENTRIES];
  logic [SW-1:0]   ord_a [POOL_ENTRIES];
  logic [CW-1:0]   cnt_f, cnt_a;
  logic [POOL_ENTRIES-1:0] taken;
  logic [CW-1:0]   pos;

  // Region memories
  logic [63:0] start_mem [POOL_ENTRIES];
  logic [63:0] len_mem   [POOL_ENTRIES];
  logic [63:0] rd_start, rd_len;

  logic [SW-1:0] cur_slot, save_r, spare, sel_slot, wr_slot;
  logic [63:0]   key_r, acc_r;
  logic [CW-1:0] cnt_sel;
  logic [CW:0]   used_sum, spare_cnt;
  logic [1:0]    need;

  // Compare pipeline
  logic [64:0] sum_r, sat_sum;
  logic [63:0] gap_r, mask_r, amh_r, negb_r, bp1_r, sat_r;
  logic        hit_r, hlta_r, hgtb_r;
  logic [63:0] l_r, d_r, at_r, clip_r;
  logic        fit1_r, sumhit_r, fwdok_r;
  logic [63:0] lmb_r, rem_r, atsz_r;
  logic        blt_r, llta_r, fit2_r;

  logic [63:0] wr_start_data, wr_len_data;
  logic [5:0]  lim6;
  logic [KW-1:0] dump_k, pos_p1;

  // Latch the request and the working keys
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      type_r   <= req_type;
      base_r   <= base_addr;
      size_r   <= size_value;
      tail_r   <= range_tail;
      align_r  <= align_bytes;
      usable_r <= usable;
      used_r   <= dump_used;
      limit_r  <= dump_limit;
      key_r    <= base_addr;
    end else if (cmd.key_sum) begin
      key_r <= sum_r[63:0];
    end
    if (cmd.acc_rd) begin
      acc_r <= rd_len;
    end else if (cmd.acc_sat) begin
      acc_r <= sat_r;
    end
    if (cmd.save_slot) begin
      save_r <= cur_slot;
    end
  end

  // Pick the lowest untaken slot
  always_comb begin
    spare = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!taken[i]) begin
        spare = SW'(i);
      end
    end
  end

  assign sel_slot = cmd.list ? ord_a[pos[SW-1:0]] : ord_f[pos[SW-1:0]];
  assign cnt_sel  = cmd.list ? cnt_a : cnt_f;

  always_comb begin
    case (cmd.slot)
      SL_CUR:  wr_slot = cur_slot;
      SL_SAVE: wr_slot = save_r;
      default: wr_slot = spare;
    endcase
  end

  // Update the ordered lists, their counts and the taken bits
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      if (cmd.list) begin
        ord_a[0] <= wr_slot;
        for (int k = 1; k < POOL_ENTRIES; k++) ord_a[k] <= ord_a[k-1];
      end else begin
        ord_f[0] <= wr_slot;
        for (int k = 1; k < POOL_ENTRIES; k++) ord_f[k] <= ord_f[k-1];
      end
    end else if (cmd.drop) begin
      for (int k = 0; k < POOL_ENTRIES - 1; k++) begin
        if (CW'(k) >= pos) begin
          if (cmd.list) begin
            ord_a[k] <= ord_a[k+1];
          end else begin
            ord_f[k] <= ord_f[k+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_f <= '0;
      cnt_a <= '0;
      taken <= '0;
      pos   <= '0;
    end else begin
      if (cmd.put) begin
        taken[wr_slot] <= 1'b1;
        if (cmd.list) cnt_a <= cnt_a + 1'b1;
        else          cnt_f <= cnt_f + 1'b1;
      end else if (cmd.drop) begin
        taken[sel_slot] <= 1'b0;
        if (cmd.list) cnt_a <= cnt_a - 1'b1;
        else          cnt_f <= cnt_f - 1'b1;
      end
      if (cmd.pos_clr) begin
        pos <= '0;
      end else if (cmd.pos_inc) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Select write data
  always_comb begin
    case (cmd.wr_start)
      SS_BASE: wr_start_data = base_r;
      SS_BP1:  wr_start_data = bp1_r;
      SS_H:    wr_start_data = rd_start;
      SS_AT:   wr_start_data = at_r;
      SS_ATSZ: wr_start_data = atsz_r;
      default: wr_start_data = base_r;
    endcase
    case (cmd.wr_len)
      LS_CLIP: wr_len_data = clip_r;
      LS_LMB:  wr_len_data = lmb_r;
      LS_AMH:  wr_len_data = amh_r;
      LS_GAP:  wr_len_data = gap_r;
      LS_SIZE: wr_len_data = size_r;
      LS_REM:  wr_len_data = rem_r;
      LS_SAT:  wr_len_data = sat_r;
      LS_ACC:  wr_len_data = acc_r;
      default: wr_len_data = size_r;
    endcase
  end

  // Region memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_start != SS_NONE) begin
      start_mem[wr_slot] <= wr_start_data;
    end
    if (cmd.rd) begin
      rd_start <= start_mem[sel_slot];
      cur_slot <= sel_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_len != LS_NONE) begin
      len_mem[wr_slot] <= wr_len_data;
    end
    if (cmd.rd) begin
      rd_len <= len_mem[sel_slot];
    end
  end

  // Entry compare pipeline, three register stages
  assign sat_sum = {1'b0, acc_r} + {1'b0, rd_len};

  always_ff @(posedge clk) begin
    sum_r  <= {1'b0, rd_start} + {1'b0, rd_len};
    mask_r <= {31'd0, align_r} - 64'd1;
    gap_r  <= (~rd_start + 64'd1) & mask_r;
    hit_r  <= (rd_start == key_r);
    amh_r  <= base_r - rd_start;
    negb_r <= 64'd0 - base_r;
    bp1_r  <= tail_r + 64'd1;
    sat_r  <= sat_sum[64] ? {64{1'b1}} : sat_sum[63:0];
    hlta_r <= (rd_start < base_r);
    hgtb_r <= (rd_start > tail_r);

    l_r      <= sum_r[63:0] - 64'd1;
    d_r      <= rd_len - gap_r;
    fit1_r   <= (gap_r < rd_len);
    at_r     <= rd_start + gap_r;
    sumhit_r <= (sum_r[63:0] == base_r) && (base_r != 64'd0);
    fwdok_r  <= (sum_r[63:0] != 64'd0);
    clip_r   <= ((base_r != 64'd0) && (size_r > negb_r)) ? negb_r : size_r;

    blt_r  <= (tail_r < l_r);
    llta_r <= (l_r < base_r);
    lmb_r  <= l_r - tail_r;
    fit2_r <= (d_r >= size_r);
    rem_r  <= d_r - size_r;
    atsz_r <= at_r + size_r;
  end

  // Status toward the controller
  assign used_sum  = {1'b0, cnt_f} + {1'b0, cnt_a};
  assign spare_cnt = (CW+1)'(POOL_ENTRIES) - used_sum;
  assign need      = {1'b0, (gap_r != 64'd0)} + {1'b0, (rem_r != 64'd0)};
  assign lim6      = (limit_r > 6'd32) ? 6'd32 : limit_r;
  assign dump_k    = (KW'(cnt_sel) < KW'(lim6)) ? KW'(cnt_sel) : KW'(lim6);
  assign pos_p1    = KW'(pos) + KW'(1);

  always_comb begin
    st.req_type    = type_r;
    st.usable_ok   = usable_r && (size_r != 64'd0);
    st.a_gt_b      = (base_r > tail_r);
    // a zero size is rejected together with a bad alignment
    st.bad_align   = (size_r == 64'd0) || (align_r == 33'd0) ||
                     ((align_r & (align_r - 33'd1)) != 33'd0);
    st.dump_used   = used_r;
    st.dump_empty  = (dump_k == '0);
    st.dump_last   = (pos_p1 == dump_k);
    st.more        = (pos < cnt_sel);
    st.spare_zero  = (spare_cnt == '0);
    st.spare_short = (spare_cnt < (CW+1)'(need));
    st.split       = hlta_r && blt_r;
    st.outside     = llta_r || hgtb_r;
    st.contain     = !hlta_r && !blt_r;
    st.h_lt_a      = hlta_r;
    st.fit         = fit1_r && fit2_r;
    st.gap_nz      = (gap_r != 64'd0);
    st.rem_nz      = (rem_r != 64'd0);
    st.hit         = hit_r;
    st.fwd_ok      = fwdok_r;
    st.sum_hit     = sumhit_r;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_STATUS: begin
        status       <= cmd.code;
        result_addr  <= cmd.addr_en ? at_r : 64'd0;
        entry_start  <= 64'd0;
        entry_length <= 64'd0;
        entry_number <= 6'd0;
        last         <= 1'b1;
      end
      EM_DUMP: begin
        status       <= ST_OK;
        result_addr  <= 64'd0;
        entry_start  <= rd_start;
        entry_length <= rd_len;
        entry_number <= pos_p1[5:0];
        last         <= st.dump_last;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    used_sum <= (CW+1)'(POOL_ENTRIES))
    else $error("list counts exceed pool");
  a_put_drop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.put && cmd.drop))
    else $error("insert and removal in one cycle");
  a_rd_in_list: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (pos < cnt_sel))
    else $error("read past list end");
  a_spare_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.put && cmd.slot == SL_SPARE) |-> (spare_cnt != '0))
    else $error("insert with no spare slot");
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("results in back-to-back cycles");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for first_fit_region_allocator_top. A behavioral copy of the
// region pool predicts every result of each accepted request. Requests are
// a short directed list followed by random add, reserve, allocate, free,
// dump and invalid-code requests with random gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffra_pkg::*;

  localparam int SLOTS = 32;
  localparam longint unsigned CYCLE_LIMIT = 1000000;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] addr;
    logic [63:0] es;
    logic [63:0] el;
    logic [5:0]  num;
    logic        last;
  } region_result_t;

  // Pool predictor plus queue of pending results
  class region_book;
    logic [63:0] rstart[SLOTS];
    logic [63:0] rlen[SLOTS];
    bit          taken[SLOTS];
    bit          alc[SLOTS];
    int          rank[SLOTS];
    int          ord[SLOTS];
    region_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
      foreach (taken[i]) begin
        taken[i] = 0;
        alc[i] = 0;
        rank[i] = 0;
        rstart[i] = '0;
        rlen[i] = '0;
      end
    endfunction

    function int spare_slot();
      for (int i = 0; i < SLOTS; i++)
        if (!taken[i]) return i;
      return -1;
    endfunction

    function int spare_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
        if (!taken[i]) n++;
      return n;
    endfunction

    function void put_head(int s, bit a, logic [63:0] st, logic [63:0] ln);
      for (int j = 0; j < SLOTS; j++)
        if (taken[j] && alc[j] == a) rank[j]++;
      taken[s] = 1;
      alc[s] = a;
      rank[s] = 0;
      rstart[s] = st;
      rlen[s] = ln;
    endfunction

    function void drop(int s);
      for (int j = 0; j < SLOTS; j++)
        if (taken[j] && alc[j] == alc[s] && rank[j] > rank[s]) rank[j]--;
      taken[s] = 0;
    endfunction

    // Fill ord with one list in list order
    function int list_order(bit a);
      int n;
      n = 0;
      foreach (ord[i]) ord[i] = 0;
      for (int i = 0; i < SLOTS; i++)
        if (taken[i] && alc[i] == a) begin
          if (rank[i] < SLOTS) ord[rank[i]] = i;
          n++;
        end
      return n;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ALL_ONES : s[63:0];
    endfunction

    function logic [1:0] do_add(logic [63:0] base, logic [63:0] len, bit ok);
      int s;
      if (!ok || len == 0) return ST_NONE;
      s = spare_slot();
      if (s < 0) return ST_FULL;
      if (base != 0 && len > (64'd0 - base)) len = 64'd0 - base;
      put_head(s, 0, base, len);
      return ST_OK;
    endfunction

    function logic [1:0] do_reserve(logic [63:0] a, logic [63:0] b);
      int snap[SLOTS];
      int n, s, sp;
      bit changed;
      logic [63:0] h, l;
      changed = 0;
      if (a > b) return ST_NONE;
      n = list_order(0);
      snap = ord;
      for (int i = 0; i < n; i++) begin
        s = snap[i];
        if (!taken[s] || alc[s]) continue;
        h = rstart[s];
        l = h + rlen[s] - 1;
        if (h < a && b < l) begin
          sp = spare_slot();
          if (sp < 0) return ST_FULL;
          put_head(sp, 0, b + 1, l - b);
          rlen[s] = a - h;
          return ST_OK;
        end
        if (l < a || h > b) continue;
        changed = 1;
        if (a <= h && l <= b) drop(s);
        else if (h < a) rlen[s] = a - h;
        else begin
          rstart[s] = b + 1;
          rlen[s] = l - b;
        end
      end
      return changed ? ST_OK : ST_NONE;
    endfunction

    function logic [1:0] do_alloc(logic [63:0] size, logic [63:0] align,
                                  output logic [63:0] addr);
      int n, s, need;
      logic [63:0] mask, h, ln, gap, rem, at;
      addr = '0;
      if (size == 0 || align == 0 || (align & (align - 1)) != 0) return ST_NONE;
      mask = align - 1;
      n = list_order(0);
      for (int i = 0; i < n; i++) begin
        s = ord[i];
        h = rstart[s];
        ln = rlen[s];
        gap = (64'd0 - h) & mask;
        if (gap >= ln || ln - gap < size) continue;
        rem = ln - gap - size;
        need = (gap != 0) + (rem != 0);
        if (spare_count() < need) return ST_FULL;
        at = h + gap;
        if (gap != 0) put_head(spare_slot(), 0, h, gap);
        if (rem != 0) begin
          put_head(spare_slot(), 1, at, size);
          rstart[s] = at + size;
          rlen[s] = rem;
        end else begin
          drop(s);
          put_head(s, 1, at, size);
        end
        addr = at;
        return ST_OK;
      end
      return ST_NONE;
    endfunction

    function logic [1:0] do_free(logic [63:0] p);
      int n, s, q;
      bit found;
      logic [63:0] ln, t, l2;
      found = 0;
      s = 0;
      n = list_order(1);
      for (int i = 0; i < n; i++)
        if (!found && rstart[ord[i]] == p) begin
          s = ord[i];
          found = 1;
        end
      if (!found) return ST_MISS;
      ln = rlen[s];
      drop(s);
      // Merge with the free region just after
      if (p + ln - 1 != ALL_ONES) begin
        t = p + ln;
        n = list_order(0);
        for (int i = 0; i < n; i++)
          if (rstart[ord[i]] == t) begin
            ln = sat_add(ln, rlen[ord[i]]);
            drop(ord[i]);
            break;
          end
      end
      // Merge with the free region just before
      n = list_order(0);
      for (int i = 0; i < n; i++) begin
        q = ord[i];
        l2 = rstart[q] + rlen[q] - 1;
        if (l2 != ALL_ONES && l2 + 1 == p) begin
          rlen[q] = sat_add(rlen[q], ln);
          return ST_OK;
        end
      end
      put_head(s, 0, p, ln);
      return ST_OK;
    endfunction

    function void push(logic [1:0] st, logic [63:0] a, logic [63:0] es,
                       logic [63:0] el, int num, bit lst);
      region_result_t r;
      r.status = st;
      r.addr = a;
      r.es = es;
      r.el = el;
      r.num = num[5:0];
      r.last = lst;
      pending.push_back(r);
    endfunction

    // Note an accepted request and queue its results
    function void note_request(logic [2:0] rt, logic [63:0] base, logic [63:0] size,
                               logic [63:0] tail, logic [32:0] align, bit ok,
                               bit du, logic [5:0] lim);
      logic [1:0] st;
      logic [63:0] a;
      int n, k, limit;
      a = '0;
      if (rt == RQ_DUMP) begin
        n = list_order(du);
        limit = (lim > 32) ? 32 : lim;
        k = (n < limit) ? n : limit;
        if (k == 0) push(ST_NONE, 0, 0, 0, 0, 1);
        for (int i = 0; i < k; i++)
          push(ST_OK, 0, rstart[ord[i]], rlen[ord[i]], i + 1, i + 1 == k);
        return;
      end
      case (rt)
        RQ_ADD:     st = do_add(base, size, ok);
        RQ_RESERVE: st = do_reserve(base, tail);
        RQ_ALLOC:   st = do_alloc(size, {31'd0, align}, a);
        RQ_FREE:    st = do_free(base);
        default:    st = ST_NONE;
      endcase
      push(st, (st == ST_OK) ? a : 64'd0, 0, 0, 0, 1);
    endfunction

    function void check_field(string nm, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $display("%0t: mismatch %s expected %h actual %h", $time, nm, exp, act);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [1:0] st, logic [63:0] a, logic [63:0] es,
                               logic [63:0] el, logic [5:0] num, logic lst);
      region_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %h addr %h", $time, st, a);
        errors++;
        return;
      end
      r = pending.pop_front();
      check_field("status", r.status, st);
      check_field("result_addr", r.addr, a);
      check_field("entry_start", r.es, es);
      check_field("entry_length", r.el, el);
      check_field("entry_number", r.num, num);
      check_field("last", r.last, lst);
    endfunction

    // Start of some allocated region, or a random address if none
    function logic [63:0] pick_allocated();
      int c[$];
      for (int i = 0; i < SLOTS; i++)
        if (taken[i] && alc[i]) c.push_back(i);
      if (c.size() == 0) return {$urandom, $urandom};
      return rstart[c[$urandom_range(0, c.size() - 1)]];
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  req_type = '0;
  logic [63:0] base_addr = '0;
  logic [63:0] size_value = '0;
  logic [63:0] range_tail = '0;
  logic [32:0] align_bytes = '0;
  logic        usable = 0;
  logic        dump_used = 0;
  logic [5:0]  dump_limit = '0;
  logic        result_strobe;
  logic [1:0]  status;
  logic [63:0] result_addr;
  logic [63:0] entry_start;
  logic [63:0] entry_length;
  logic [5:0]  entry_number;
  logic        last;

  region_book book = new();
  longint unsigned cycles = 0;

  first_fit_region_allocator_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .base_addr(base_addr), .size_value(size_value),
    .range_tail(range_tail), .align_bytes(align_bytes), .usable(usable),
    .dump_used(dump_used), .dump_limit(dump_limit),
    .result_strobe(result_strobe), .status(status), .result_addr(result_addr),
    .entry_start(entry_start), .entry_length(entry_length),
    .entry_number(entry_number), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watch both channels and give up past the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst && start && !busy)
      book.note_request(req_type, base_addr, size_value, range_tail, align_bytes,
                        usable, dump_used, dump_limit);
    if (!rst && result_strobe)
      book.check_result(status, result_addr, entry_start, entry_length,
                        entry_number, last);
  end

  // Present one request and hold it until the transfer
  task automatic issue(logic [2:0] rt, logic [63:0] base, logic [63:0] size,
                       logic [63:0] tail, logic [32:0] align, logic ok,
                       logic du, logic [5:0] lim);
    req_type <= rt;
    base_addr <= base;
    size_value <= size;
    range_tail <= tail;
    align_bytes <= align;
    usable <= ok;
    dump_used <= du;
    dump_limit <= lim;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  task automatic dump_both();
    issue(RQ_DUMP, 0, 0, 0, 1, 0, 0, 6'd32);
    issue(RQ_DUMP, 0, 0, 0, 1, 0, 1, 6'd63);
  endtask

  // One random request, mostly well-formed
  task automatic random_request();
    int pick;
    logic [63:0] a, b;
    logic [32:0] al;
    pick = $urandom_range(0, 99);
    al = 33'd1 << $urandom_range(0, 8);
    a = 64'($urandom_range(0, 4095)) * 16;
    if (pick < 15) begin
      if ($urandom_range(0, 9) == 0)
        issue(RQ_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 0, al,
              $urandom_range(0, 1), 0, 0);
      else
        issue(RQ_ADD, a, $urandom_range(16, 4096), {$urandom, $urandom}, al, 1,
              $urandom_range(0, 1), $urandom_range(0, 63));
    end else if (pick < 28) begin
      b = a + $urandom_range(0, 600);
      if ($urandom_range(0, 9) == 0) b = {$urandom, $urandom};
      issue(RQ_RESERVE, a, {$urandom, $urandom}, b, al, $urandom_range(0, 1), 0, 0);
    end else if (pick < 60) begin
      if ($urandom_range(0, 14) == 0) al = {$urandom_range(0, 1), $urandom};
      issue(RQ_ALLOC, {$urandom, $urandom}, $urandom_range(1, 512), 0, al, 0, 0, 0);
    end else if (pick < 85) begin
      b = ($urandom_range(0, 4) != 0) ? book.pick_allocated() : a;
      issue(RQ_FREE, b, 0, 0, al, 0, 0, 0);
    end else if (pick < 96) begin
      issue(RQ_DUMP, 0, 0, 0, al, 0, $urandom_range(0, 1), $urandom_range(0, 63));
    end else begin
      issue($urandom_range(5, 7), {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom}, {$urandom_range(0, 1), $urandom},
            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 63));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty dumps, bad requests, edges of every field
    issue(RQ_DUMP, 0, 0, 0, 1, 0, 0, 6'd5);
    issue(RQ_ADD, 64'h1000, 0, 0, 1, 1, 0, 0);
    issue(RQ_ADD, 64'h1000, 64'h100, 0, 1, 0, 0, 0);
    issue(RQ_ADD, 64'hFFFF_FFFF_FFFF_F000, ALL_ONES, 0, 1, 1, 0, 0);
    issue(RQ_ADD, 64'h1000, 64'h1000, 0, 1, 1, 0, 0);
    issue(RQ_ADD, 0, ALL_ONES, 0, 1, 1, 0, 0);
    issue(RQ_RESERVE, 0, 0, 64'h1_0000, 1, 0, 0, 0);
    issue(RQ_RESERVE, 64'h500, 0, 64'h400, 1, 0, 0, 0);
    issue(RQ_RESERVE, 64'hFFFF_FFFF_FFFF_F100, 0, 64'hFFFF_FFFF_FFFF_F1FF, 1, 0, 0, 0);
    issue(RQ_ADD, 64'h2000, 64'h1000, 0, 1, 1, 0, 0);
    issue(RQ_ALLOC, 0, 0, 0, 33'd16, 0, 0, 0);
    issue(RQ_ALLOC, 0, 64'h10, 0, 33'd0, 0, 0, 0);
    issue(RQ_ALLOC, 0, 64'h10, 0, 33'd3, 0, 0, 0);
    issue(RQ_ALLOC, 0, 64'h10, 0, 33'h1_0000_0000, 0, 0, 0);
    issue(RQ_ALLOC, 0, 64'h28, 0, 33'd64, 0, 0, 0);
    issue(RQ_ALLOC, 0, 64'hF00, 0, 33'd256, 0, 0, 0);
    issue(RQ_ALLOC, 0, ALL_ONES, 0, 33'd1, 0, 0, 0);
    dump_both();
    issue(RQ_FREE, 64'h1234, 0, 0, 1, 0, 0, 0);
    issue(RQ_FREE, book.pick_allocated(), 0, 0, 1, 0, 0, 0);
    issue(RQ_FREE, book.pick_allocated(), 0, 0, 1, 0, 0, 0);
    issue(3'd5, ALL_ONES, ALL_ONES, ALL_ONES, '1, 1, 1, 6'd63);
    issue(3'd7, 0, 0, 0, 0, 0, 0, 0);
    dump_both();
    issue(RQ_DUMP, 0, 0, 0, 1, 0, 0, 6'd0);

    // Hold the sender until every result is back
    drain();

    // Random sequences, gaps only in the earlier part
    for (int i = 0; i < 360; i++) begin
      random_request();
      if (i < 300 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 19));
      if (i == 150) drain();
    end

    drain();
    start <= 0;
    repeat (100) @(posedge clk);
    if (book.errors == 0 && book.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
